FILE: rtl/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [20:0] MAX_POINT  = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
  localparam logic [20:0] PLANE1     = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  // one result transaction
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        decode_error;
    logic        end_of_text;
    logic        run_last;
  } res_t;

  // what one accepted byte produces
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } dec_t;

  // smallest legal code point for a sequence of (len + 1) bytes
  function automatic logic [20:0] min_point(input logic [1:0] len);
    logic [20:0] m;
    unique case (len)
      2'd0:    m = 21'h000000;
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      default: m = 21'h010000;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/utt_decoder.sv
// ----------------------------------------------------------------------------
// utt_decoder
// Sequence state and combinational decode of one UTF-8 byte into results.
// ----------------------------------------------------------------------------
module utt_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic [7:0]    in_byte,
  input  logic          in_string_end,
  output utt_pkg::dec_t dec
);
  import utt_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  left_r, left_nxt;
  logic [1:0]  len_r, len_nxt;
  logic        disc_r, disc_nxt;
  logic        fail;
  logic [20:0] offs;

  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    disc_nxt    = disc_r;
    fail        = 1'b0;
    offs        = '0;
    dec         = '0;
    if (disc_r) begin
      if (in_string_end) begin
        partial_nxt = '0;
        left_nxt    = '0;
        len_nxt     = '0;
        disc_nxt    = 1'b0;
        dec.n       = 2'd1;
        dec.res0.end_of_text = 1'b1;
        dec.res0.run_last    = 1'b1;
      end
    end else begin
      if (left_r == 2'd0) begin
        priority if (!in_byte[7]) begin
          partial_nxt = {13'd0, in_byte};
          len_nxt     = 2'd0;
        end else if (in_byte[7:5] == 3'b110) begin
          partial_nxt = {16'd0, in_byte[4:0]};
          len_nxt     = 2'd1;
          left_nxt    = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          partial_nxt = {17'd0, in_byte[3:0]};
          len_nxt     = 2'd2;
          left_nxt    = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          partial_nxt = {18'd0, in_byte[2:0]};
          len_nxt     = 2'd3;
          left_nxt    = 2'd3;
        end else begin
          fail = 1'b1;
        end
      end else begin
        if (in_byte[7:6] != 2'b10) begin
          fail = 1'b1;
        end else begin
          partial_nxt = {partial_r[14:0], in_byte[5:0]};
          left_nxt    = left_r - 2'd1;
        end
      end

      // cut off at the end of the string
      if (!fail && left_nxt != 2'd0 && in_string_end) begin
        fail = 1'b1;
      end
      // overlong, out of range or surrogate value
      if (!fail && left_nxt == 2'd0) begin
        if (partial_nxt < min_point(len_nxt) || partial_nxt > MAX_POINT ||
            (partial_nxt >= SURR_FIRST && partial_nxt <= SURR_LAST)) begin
          fail = 1'b1;
        end
      end

      if (fail) begin
        partial_nxt = '0;
        left_nxt    = '0;
        len_nxt     = '0;
        disc_nxt    = !in_string_end;
        dec.n       = 2'd1;
        dec.res0.decode_error = 1'b1;
        dec.res0.end_of_text  = in_string_end;
        dec.res0.run_last     = 1'b1;
      end else if (left_nxt == 2'd0) begin
        if (partial_nxt[20:16] == 5'd0) begin
          dec.n = 2'd1;
          dec.res0.code_unit   = partial_nxt[15:0];
          dec.res0.unit_valid  = 1'b1;
          dec.res0.end_of_text = in_string_end;
          dec.res0.run_last    = 1'b1;
        end else begin
          offs  = partial_nxt - PLANE1;
          dec.n = 2'd2;
          dec.res0.code_unit   = {HI_SURR_TAG, offs[19:10]};
          dec.res0.unit_valid  = 1'b1;
          dec.res1.code_unit   = {LO_SURR_TAG, offs[9:0]};
          dec.res1.unit_valid  = 1'b1;
          dec.res1.end_of_text = in_string_end;
          dec.res1.run_last    = 1'b1;
        end
        partial_nxt = '0;
        len_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= '0;
      len_r     <= '0;
      disc_r    <= 1'b0;
    end else if (in_accept) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      len_r     <= len_nxt;
      disc_r    <= disc_nxt;
    end
  end

  // an error mid-string must start the drop phase
  a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && dec.res0.decode_error && !in_string_end |=> disc_r)
    else $error("error without discard phase");

  // no open sequence survives the final byte
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_string_end |=> left_r == 2'd0 && !disc_r)
    else $error("state left open after string end");

  // a pair is always high surrogate then low surrogate
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    dec.n == 2'd2 |-> dec.res0.code_unit[15:10] == HI_SURR_TAG &&
                      dec.res1.code_unit[15:10] == LO_SURR_TAG)
    else $error("malformed surrogate pair");

endmodule

FILE: rtl/utt_out_queue.sv
// ----------------------------------------------------------------------------
// utt_out_queue
// Small result buffer taking up to two results a cycle, giving one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module utt_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utt_pkg::dec_t dec,
  output logic          space2,
  output logic          out_valid,
  input  logic          out_ready,
  output utt_pkg::res_t head
);
  import utt_pkg::*;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        n_push;
  logic              pop;
  logic [QPTR_W-1:0] wr_plus1;

  assign n_push    = push ? dec.n : 2'd0;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = q_r[rd_r];
  assign space2    = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign wr_plus1  = wr_r + QPTR_W'(1);
  assign cnt_nxt   = cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_r] <= dec.res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_plus1] <= dec.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QPTR_W'(n_push);
      rd_r  <= rd_r + QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // never overfilled
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // pushes only when two slots are free
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> space2)
    else $error("push without room");

  // occupancy follows the pointers
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != QCNT_W'(QDEPTH) |-> QPTR_W'(wr_r - rd_r) == cnt_r[QPTR_W-1:0])
    else $error("pointer and count disagree");

endmodule

FILE: rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Validating UTF-8 to UTF-16 transcoder, one byte in per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one byte of a UTF-8 string, with
// in_string_end high on its final byte. Output channel (out_valid/out_ready)
// carries UTF-16 units; a code point of 0x10000 and above gives two
// transactions, high surrogate first. An invalid string gives one result
// with out_decode_error set and the remaining bytes up to the final one are
// dropped; the final byte then gives a marker result with out_end_of_text.
// Units sent before an error belong to a rejected string.
// A result is offered in the cycle after its byte is accepted when
// nothing waits ahead of it in the queue.
// One byte is accepted per cycle while in_ready is high; the decode is one
// combinational pass into a four-entry result queue, and the output drains
// one unit per cycle while out_ready is high, so a pair leaves as two units.
// in_ready is high while the queue has two free slots; when the receiver
// stalls, in_ready drops once three or more results are waiting, and no
// byte is taken while it is low, even one that would give no result.
// Synchronous reset clears the sequence state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_unit_valid,
  output logic        out_decode_error,
  output logic        out_end_of_text,
  output logic        out_run_last
);
  import utt_pkg::*;

  dec_t dec;
  res_t head;
  logic in_accept;

  assign in_accept = in_valid && in_ready;

  utt_decoder u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .dec           (dec)
  );

  utt_out_queue u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .dec       (dec),
    .space2    (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_code_unit    = head.code_unit;
  assign out_unit_valid   = head.unit_valid;
  assign out_decode_error = head.decode_error;
  assign out_end_of_text  = head.end_of_text;
  assign out_run_last     = head.run_last;

endmodule

FILE: tb/tb_utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Self-checking bench for the validating UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
// Bytes of UTF-8 strings go in over a valid/ready channel. A scoreboard
// decodes every accepted byte on its own and queues the UTF-16 units, error
// results and end markers that it should cause. Each output transaction is
// checked field by field against the oldest queued result. A short directed
// set of strings covers range edges and every kind of malformed input.
// Random strings follow: mostly well-formed text, some with one flaw placed
// among valid characters, and some noise bytes. Both sides idle at random,
// and the receiver holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;
  import utt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LIVE_BYTES  = 1750;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef logic [7:0] octet_q[$];

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_LEAD,
    FLAW_BAD_CONT,
    FLAW_OVERLONG,
    FLAW_TOO_BIG,
    FLAW_SURROGATE,
    FLAW_CUT_OFF,
    FLAW_NOISE
  } flaw_e;

  // decodes accepted bytes and holds the results still owed by the block
  class utf16_scoreboard;
    res_t        expected_units[$];
    int unsigned errors;
    logic [20:0] acc;
    logic [1:0]  bytes_due;
    logic [1:0]  seq_len;
    bit          dropping;

    function new();
      errors   = 0;
      dropping = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      acc       = '0;
      bytes_due = '0;
      seq_len   = '0;
    endfunction

    function void push_unit(logic [15:0] unit, logic valid, logic err, logic eot,
                            logic last);
      res_t r;
      r.code_unit    = unit;
      r.unit_valid   = valid;
      r.decode_error = err;
      r.end_of_text  = eot;
      r.run_last     = last;
      expected_units = {expected_units, r};
    endfunction

    function void reject(logic last_byte);
      clear_sequence();
      dropping = !last_byte;
      push_unit(16'h0000, 1'b0, 1'b1, last_byte, 1'b1);
    endfunction

    // returns 1 when the byte was decoded rather than dropped
    function bit note_byte(logic [7:0] b, logic last_byte);
      logic [20:0] cp;
      logic [20:0] floor_point;
      logic [20:0] off;
      bit          live;
      live = !dropping;
      if (dropping) begin
        if (last_byte) begin
          dropping = 0;
          clear_sequence();
          push_unit(16'h0000, 1'b0, 1'b0, 1'b1, 1'b1);
        end
        return live;
      end
      if (bytes_due == 2'd0) begin
        casez (b)
          8'b0???????: begin
            acc = {13'd0, b};
            seq_len = 2'd0;
          end
          8'b110?????: begin
            acc = {16'd0, b[4:0]};
            seq_len = 2'd1;
            bytes_due = 2'd1;
          end
          8'b1110????: begin
            acc = {17'd0, b[3:0]};
            seq_len = 2'd2;
            bytes_due = 2'd2;
          end
          8'b11110???: begin
            acc = {18'd0, b[2:0]};
            seq_len = 2'd3;
            bytes_due = 2'd3;
          end
          default: begin
            reject(last_byte);
            return live;
          end
        endcase
      end else if (b[7:6] != 2'b10) begin
        reject(last_byte);
        return live;
      end else begin
        acc = {acc[14:0], b[5:0]};
        bytes_due = bytes_due - 2'd1;
      end

      // sequence still open
      if (bytes_due != 2'd0) begin
        if (last_byte) reject(last_byte);
        return live;
      end

      cp = acc;
      case (seq_len)
        2'd0:    floor_point = 21'h000000;
        2'd1:    floor_point = 21'h000080;
        2'd2:    floor_point = 21'h000800;
        default: floor_point = 21'h010000;
      endcase
      if (cp < floor_point || cp > MAX_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
        reject(last_byte);
        return live;
      end

      clear_sequence();
      if (cp <= 21'h00FFFF) begin
        push_unit(cp[15:0], 1'b1, 1'b0, last_byte, 1'b1);
      end else begin
        off = cp - PLANE1;
        push_unit({HI_SURR_TAG, off[19:10]}, 1'b1, 1'b0, 1'b0, 1'b0);
        push_unit({LO_SURR_TAG, off[9:0]}, 1'b1, 1'b0, last_byte, 1'b1);
      end
      return live;
    endfunction

    function void field_diff(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_unit(res_t got);
      res_t want;
      if (expected_units.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got unit %h valid %b",
                 $time, got.code_unit, got.unit_valid);
        return;
      end
      want = expected_units.pop_front();
      field_diff("code_unit", 32'(want.code_unit), 32'(got.code_unit));
      field_diff("unit_valid", 32'(want.unit_valid), 32'(got.unit_valid));
      field_diff("decode_error", 32'(want.decode_error), 32'(got.decode_error));
      field_diff("end_of_text", 32'(want.end_of_text), 32'(got.end_of_text));
      field_diff("run_last", 32'(want.run_last), 32'(got.run_last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_string_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_unit_valid;
  logic        out_decode_error;
  logic        out_end_of_text;
  logic        out_run_last;

  utf16_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned live_bytes = 0;
  int unsigned tx_gap_pct = 0;

  utf8_to_utf16_transcoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_string_end    (in_string_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_unit    (out_code_unit),
    .out_unit_valid   (out_unit_valid),
    .out_decode_error (out_decode_error),
    .out_end_of_text  (out_end_of_text),
    .out_run_last     (out_run_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // random code point whose natural encoding is len bytes
  function automatic int unsigned pick_point(int len);
    int unsigned lo;
    int unsigned hi;
    int unsigned cp;
    case (len)
      1:       begin lo = 'h0;     hi = 'h7F;     end
      2:       begin lo = 'h80;    hi = 'h7FF;    end
      3:       begin lo = 'h800;   hi = 'hFFFF;   end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? hi : lo;
    else cp = $urandom_range(lo, hi);
    // keep clear of the surrogate range
    if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
    return cp;
  endfunction

  // encodes cp in len bytes, overlong forms included
  function automatic void encode(ref octet_q q, input int unsigned cp, input int len);
    case (len)
      1: q = {q, cp[7:0]};
      2: begin
        q = {q, 8'(8'hC0 | ((cp >> 6) & 8'h1F))};
        q = {q, 8'(8'h80 | (cp & 8'h3F))};
      end
      3: begin
        q = {q, 8'(8'hE0 | ((cp >> 12) & 8'h0F))};
        q = {q, 8'(8'h80 | ((cp >> 6) & 8'h3F))};
        q = {q, 8'(8'h80 | (cp & 8'h3F))};
      end
      default: begin
        q = {q, 8'(8'hF0 | ((cp >> 18) & 8'h07))};
        q = {q, 8'(8'h80 | ((cp >> 12) & 8'h3F))};
        q = {q, 8'(8'h80 | ((cp >> 6) & 8'h3F))};
        q = {q, 8'(8'h80 | (cp & 8'h3F))};
      end
    endcase
  endfunction

  function automatic octet_q build_string();
    octet_q s;
    octet_q t;
    flaw_e  flaw;
    int     len;
    int     k;
    logic [7:0] b;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) flaw = FLAW_NONE;
    else flaw = flaw_e'($urandom_range(FLAW_BAD_LEAD, FLAW_NOISE));

    repeat ($urandom_range(flaw == FLAW_NONE ? 1 : 0, 4)) begin
      len = $urandom_range(1, 4);
      encode(s, pick_point(len), len);
    end

    case (flaw)
      FLAW_BAD_LEAD: begin
        if ($urandom_range(0, 1)) s = {s, 8'($urandom_range(8'h80, 8'hBF))};
        else s = {s, 8'($urandom_range(8'hF8, 8'hFF))};
      end
      FLAW_BAD_CONT: begin
        len = $urandom_range(2, 4);
        encode(t, pick_point(len), len);
        k = $urandom_range(1, len - 1);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[7] = 1'b0;
        t[k] = b;
        s = {s, t};
      end
      FLAW_OVERLONG: begin
        len = $urandom_range(1, 3);
        encode(s, pick_point(len), $urandom_range(len + 1, 4));
      end
      FLAW_TOO_BIG: encode(s, $urandom_range('h110000, 'h1FFFFF), 4);
      FLAW_SURROGATE: encode(s, $urandom_range('hD800, 'hDFFF), 3);
      FLAW_CUT_OFF: begin
        len = $urandom_range(2, 4);
        encode(t, pick_point(len), len);
        repeat ($urandom_range(1, len - 1)) t = t[0:$-1];
        // must sit at the very end of the string
        return {s, t};
      end
      FLAW_NOISE: begin
        repeat ($urandom_range(1, 6)) s = {s, 8'($urandom_range(0, 255))};
      end
      default: ;
    endcase

    if (flaw != FLAW_NONE) begin
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(1, 4);
        encode(s, pick_point(len), len);
      end
    end
    return s;
  endfunction

  task automatic send_octet(logic [7:0] b, logic last_byte);
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_string_end <= last_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_byte(b, last_byte)) live_bytes++;
  endtask

  task automatic idle_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_string(octet_q s);
    for (int i = 0; i < s.size(); i++) begin
      send_octet(s[i], i == s.size() - 1);
      if ($urandom_range(0, 99) < tx_gap_pct) idle_input(pick_gap());
    end
  endtask

  initial begin : stimulus
    octet_q s;
    int unsigned strings;
    strings = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range edges, pairs, and each kind of malformed string
    s = '{8'h00, 8'hC2, 8'h80};                  send_string(s);
    s = '{8'hEF, 8'hBF, 8'hBF, 8'h7F};           send_string(s);
    s = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};           send_string(s);
    s = '{8'hFF, 8'h41, 8'h80};                  send_string(s);  // bad lead, rest dropped
    s = '{8'hC0, 8'h80};                         send_string(s);  // overlong
    s = '{8'hED, 8'hA0, 8'h80};                  send_string(s);  // surrogate value
    s = '{8'hF4, 8'h90, 8'h80, 8'h80};           send_string(s);  // above the last plane
    s = '{8'hE2, 8'h82};                         send_string(s);  // cut off at the end
    s = '{8'hC3, 8'h41};                         send_string(s);  // bad continuation

    while (live_bytes < LIVE_BYTES) begin
      if (strings % 40 == 0) tx_gap_pct = pick_pct();
      send_string(build_string());
      strings++;
    end
    in_valid <= 1'b0;

    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    res_t        got;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned seen;
    int unsigned pct;
    int unsigned cyc;
    stall_left = 0;
    hold_left  = 0;
    seen       = 0;
    pct        = 0;
    cyc        = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_valid && out_ready) begin
        got.code_unit    = out_code_unit;
        got.unit_valid   = out_unit_valid;
        got.decode_error = out_decode_error;
        got.end_of_text  = out_end_of_text;
        got.run_last     = out_run_last;
        sb.check_unit(got);
        seen++;
        // one long hold-off so the block backs up and stalls its input
        if (seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (cyc % 256 == 0) pct = pick_pct();
      cyc++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < pct) begin
        out_ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

endmodule
